[rtl/kabf_pkg.sv]
// ----------------------------------------------------------------------------
// kabf_pkg
// shared constants and register indexes for the angle and bias filter
// ----------------------------------------------------------------------------
package kabf_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int CSR_WIDTH      = 31;
   localparam int CSR_IDX_WIDTH  = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEASURE_NOISE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ANGLE_NOISE   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIAS_NOISE    = 2'd2;

   localparam logic [CSR_WIDTH-1:0] MEASURE_NOISE_RST = 31'd503316;
   localparam logic [CSR_WIDTH-1:0] ANGLE_NOISE_RST   = 31'd16777;
   localparam logic [CSR_WIDTH-1:0] BIAS_NOISE_RST    = 31'd50332;

   localparam int QUOT_BITS = 57;

endpackage

[rtl/kalman_angle_bias_filter.sv]
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state kalman filter fusing a measured angle with a gyro rate
// ----------------------------------------------------------------------------
// A restart request is answered in the cycle after it is accepted. An update
// request skips both divisions when the innovation variance is not positive.
// One 33x33 signed multiplier is stepped through the ten predict and correct
// products. The two gains come from a restoring divider that yields one
// quotient bit a cycle: two divisions of 57 quotient bits. The block takes no
// new request until the response has been accepted, and is ready again in the
// cycle after that. Values saturate to min(DATA_WIDTH, 32) bits.
module kalman_angle_bias_filter #(
   parameter int DATA_WIDTH = kabf_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [31:0]                   req_measured_angle,
   input  logic signed [31:0]                   req_gyro_rate,
   input  logic [15:0]                          req_time_step,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [31:0]                   rsp_angle_estimate,
   output logic signed [31:0]                   rsp_bias_estimate,
   input  logic                                 csr_write_enable,
   input  logic [kabf_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [kabf_pkg::CSR_WIDTH-1:0]       csr_write_data
);

   localparam int SB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
   localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
   localparam int QB = kabf_pkg::QUOT_BITS;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_RSP  = 6'b001000
   } state_type;

   // sequencer steps
   typedef enum logic [4:0] {
      SP_D, SP_ANG, SP_T1, SP_INNER, SP_P00, SP_P11, SP_S,
      SP_K0, SP_K1, SP_UA, SP_UB, SP_CAA, SP_CAB, SP_CBA, SP_CBB
   } step_type;

   function automatic logic signed [63:0] sat(input logic signed [63:0] x);
      if (x > SMAX) return SMAX;
      if (x < SMIN) return SMIN;
      return x;
   endfunction

   function automatic logic signed [63:0] rshift(input logic signed [65:0] x,
                                                 input logic s24);
      logic signed [63:0] r;
      begin
         r = s24 ? 64'((x + 66'sd8388608) >>> 24) : 64'((x + 66'sd32768) >>> 16);
         return r;
      end
   endfunction

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic [30:0] rn_ff, qa_ff, qb_ff;
   logic signed [31:0] angle_ff, bias_ff, caa_ff, cab_ff, cba_ff, cbb_ff;
   logic signed [31:0] meas_ff, rate_ff;
   logic [15:0] dt_ff;
   logic signed [31:0] d_ff, t1_ff, inner_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [31:0] y_ff, s_ff, k0_ff, k1_ff;

   // shared multiplier operands and registered product
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod_ff;
   logic               phase_ff;

   // restoring divider: |num| << 24 by s, one bit a cycle
   logic [QB-1:0]  dq_ff;
   logic [QB-1:0]  dn_ff;
   logic [32:0]    dr_ff;
   logic [5:0]     dcnt_ff;
   logic           dneg_ff;
   logic [33:0]    dtrial;
   logic [QB:0]    qsigned;

   function automatic logic s_next_pos(input logic signed [31:0] p00);
      return sat(64'(p00) + sat(64'(rn_ff))) > 64'sd0;
   endfunction

   always_comb begin
      ma = '0;
      mb = '0;
      case (step_ff)
         SP_ANG:   begin ma = 33'(d_ff);     mb = {17'd0, dt_ff}; end
         SP_T1:    begin ma = {17'd0, dt_ff}; mb = 33'(cbb_ff);  end
         SP_P00:   begin ma = {17'd0, dt_ff}; mb = 33'(inner_ff); end
         SP_P11:   begin ma = 33'(sat(64'(qb_ff))); mb = {17'd0, dt_ff}; end
         SP_UA:    begin ma = 33'(k0_ff); mb = 33'(y_ff);   end
         SP_UB:    begin ma = 33'(k1_ff); mb = 33'(y_ff);   end
         SP_CAA:   begin ma = 33'(k0_ff); mb = 33'(p00_ff); end
         SP_CAB:   begin ma = 33'(k0_ff); mb = 33'(p01_ff); end
         SP_CBA:   begin ma = 33'(k1_ff); mb = 33'(p00_ff); end
         SP_CBB:   begin ma = 33'(k1_ff); mb = 33'(p01_ff); end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   assign dtrial  = {dr_ff, dn_ff[QB-1]} - {1'b0, s_ff[31:0]};
   assign qsigned = dneg_ff ? -{1'b0, dq_ff} : {1'b0, dq_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP);
   assign rsp_angle_estimate = angle_ff;
   assign rsp_bias_estimate  = bias_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_kind ? ST_MUL : ST_RSP;
               step_in  = SP_D;
            end
         end
         ST_MUL: begin
            if (step_ff == SP_S) begin
               state_in = (s_next_pos(p00_ff)) ? ST_DIV : ST_MUL;
               step_in  = (s_next_pos(p00_ff)) ? SP_K0 : SP_UA;
            end else if (step_ff == SP_CBB && phase_ff) begin
               state_in = ST_RSP;
            end else if (step_ff == SP_D || step_ff == SP_INNER || phase_ff) begin
               step_in = step_type'(step_ff + 5'd1);
            end
         end
         ST_DIV: begin
            if (dcnt_ff == 6'(QB + 1)) begin
               if (step_ff == SP_K1) begin
                  state_in = ST_MUL;
                  step_in  = SP_UA;
               end else begin
                  step_in = SP_K1;
               end
            end
         end
         ST_RSP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= SP_D;
         phase_ff <= 1'b0;
         rn_ff    <= kabf_pkg::MEASURE_NOISE_RST;
         qa_ff    <= kabf_pkg::ANGLE_NOISE_RST;
         qb_ff    <= kabf_pkg::BIAS_NOISE_RST;
         angle_ff <= '0;
         bias_ff  <= '0;
         caa_ff   <= '0;
         cab_ff   <= '0;
         cba_ff   <= '0;
         cbb_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_write_enable) begin
            case (csr_index)
               kabf_pkg::CSR_MEASURE_NOISE: rn_ff <= csr_write_data;
               kabf_pkg::CSR_ANGLE_NOISE:   qa_ff <= csr_write_data;
               kabf_pkg::CSR_BIAS_NOISE:    qb_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_valid) begin
            meas_ff  <= 32'(sat(64'(req_measured_angle)));
            rate_ff  <= req_gyro_rate;
            dt_ff    <= req_time_step;
            phase_ff <= 1'b0;
            if (!req_kind) begin
               angle_ff <= 32'(sat(64'(req_measured_angle)));
               bias_ff  <= '0;
               caa_ff   <= '0;
               cab_ff   <= '0;
               cba_ff   <= '0;
               cbb_ff   <= '0;
            end
         end
         if (state_ff == ST_MUL) begin
            prod_ff  <= ma * mb;
            phase_ff <= (step_ff == SP_D || step_ff == SP_INNER || step_ff == SP_S)
                        ? 1'b0 : ~phase_ff;
            case (step_ff)
               SP_D: d_ff <= 32'(sat(64'(sat(64'(rate_ff))) - 64'(bias_ff)));
               SP_INNER: inner_ff <= 32'(sat(64'(t1_ff) - 64'(cab_ff) - 64'(cba_ff)
                                     + sat(64'(qa_ff))));
               SP_S: begin
                  s_ff <= 32'(sat(64'(p00_ff) + sat(64'(rn_ff))));
                  y_ff <= 32'(sat(64'(meas_ff) - 64'(angle_ff)));
                  k0_ff <= '0;
                  k1_ff <= '0;
               end
               default: ;
            endcase
            if (phase_ff) begin
               case (step_ff)
                  SP_ANG: angle_ff <= 32'(sat(64'(angle_ff) + rshift(prod_ff, 1'b0)));
                  SP_T1: begin
                     t1_ff  <= 32'(sat(rshift(prod_ff, 1'b0)));
                     p01_ff <= 32'(sat(64'(cab_ff) - sat(rshift(prod_ff, 1'b0))));
                     p10_ff <= 32'(sat(64'(cba_ff) - sat(rshift(prod_ff, 1'b0))));
                  end
                  SP_P00: p00_ff <= 32'(sat(64'(caa_ff) + rshift(prod_ff, 1'b0)));
                  SP_P11: p11_ff <= 32'(sat(64'(cbb_ff) + rshift(prod_ff, 1'b0)));
                  SP_UA:  angle_ff <= 32'(sat(64'(angle_ff) + rshift(prod_ff, 1'b1)));
                  SP_UB:  bias_ff  <= 32'(sat(64'(bias_ff) + rshift(prod_ff, 1'b1)));
                  SP_CAA: caa_ff <= 32'(sat(64'(p00_ff) - rshift(prod_ff, 1'b1)));
                  SP_CAB: cab_ff <= 32'(sat(64'(p01_ff) - rshift(prod_ff, 1'b1)));
                  SP_CBA: cba_ff <= 32'(sat(64'(p10_ff) - rshift(prod_ff, 1'b1)));
                  SP_CBB: cbb_ff <= 32'(sat(64'(p11_ff) - rshift(prod_ff, 1'b1)));
                  default: ;
               endcase
            end
         end
         if (state_ff == ST_DIV) begin
            if (dcnt_ff == '0) begin
               dneg_ff <= (step_ff == SP_K0) ? p00_ff[31] : p10_ff[31];
               dn_ff   <= (step_ff == SP_K0)
                  ? QB'({(p00_ff[31] ? 32'(-33'(p00_ff)) : 32'(p00_ff)), 24'd0})
                  : QB'({(p10_ff[31] ? 32'(-33'(p10_ff)) : 32'(p10_ff)), 24'd0});
               dr_ff   <= '0;
               dq_ff   <= '0;
               dcnt_ff <= dcnt_ff + 6'd1;
            end else if (dcnt_ff == 6'(QB + 1)) begin
               if (step_ff == SP_K0) k0_ff <= 32'(sat(64'(signed'(qsigned))));
               else k1_ff <= 32'(sat(64'(signed'(qsigned))));
               dcnt_ff <= '0;
            end else begin
               dn_ff <= {dn_ff[QB-2:0], 1'b0};
               if (!dtrial[33]) begin
                  dr_ff <= dtrial[32:0];
                  dq_ff <= {dq_ff[QB-2:0], 1'b1};
               end else begin
                  dr_ff <= {dr_ff[31:0], dn_ff[QB-1]};
                  dq_ff <= {dq_ff[QB-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 6'd1;
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while response pending");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_kind) |=> rsp_valid)
      else $error("restart response late");
   a_div_only_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (s_ff > 32'sd0)) else $error("divide by nonpositive");
`endif

endmodule

[test/kabf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_checker
// watches the request, response and register ports of the angle and bias
// filter, predicts each response from its own copy of the filter state and
// compares the responses field by field, in order
// ----------------------------------------------------------------------------
module kabf_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic signed [31:0]                   req_measured_angle,
   input  logic signed [31:0]                   req_gyro_rate,
   input  logic [15:0]                          req_time_step,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [31:0]                   rsp_angle_estimate,
   input  logic signed [31:0]                   rsp_bias_estimate,
   input  logic                                 csr_write_enable,
   input  logic [kabf_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [kabf_pkg::CSR_WIDTH-1:0]       csr_write_data,
   output int                                   fail_count,
   output int                                   outstanding
);

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } estimate_type;

   estimate_type estimates_due[$];

   longint noise_meas, noise_angle, noise_bias;
   longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   function automatic longint clamp32(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // add half then floor
   function automatic longint round_shr(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   task automatic filter_step(input logic kind, input logic signed [31:0] meas_in,
                              input logic signed [31:0] rate_in, input logic [15:0] dt_in);
      longint meas, rate, dt, d, t1, inner, p00, p01, p10, p11, y, s, k0, k1;
      meas = longint'(meas_in);
      if (!kind) begin
         est_angle = meas;
         est_bias = 0;
         p_aa = 0;
         p_ab = 0;
         p_ba = 0;
         p_bb = 0;
      end else begin
         rate = longint'(rate_in);
         dt = longint'({1'b0, dt_in});
         // predict
         d = clamp32(rate - est_bias);
         est_angle = clamp32(est_angle + round_shr(d * dt, 16));
         t1 = clamp32(round_shr(dt * p_bb, 16));
         inner = clamp32(t1 - p_ab - p_ba + noise_angle);
         p00 = clamp32(p_aa + round_shr(dt * inner, 16));
         p01 = clamp32(p_ab - t1);
         p10 = clamp32(p_ba - t1);
         p11 = clamp32(p_bb + round_shr(noise_bias * dt, 16));
         // correct
         y = clamp32(meas - est_angle);
         s = clamp32(p00 + noise_meas);
         if (s > 0) begin
            k0 = clamp32((p00 * (64'sd1 <<< 24)) / s);
            k1 = clamp32((p10 * (64'sd1 <<< 24)) / s);
         end else begin
            k0 = 0;
            k1 = 0;
         end
         est_angle = clamp32(est_angle + round_shr(k0 * y, 24));
         est_bias = clamp32(est_bias + round_shr(k1 * y, 24));
         p_aa = clamp32(p00 - round_shr(k0 * p00, 24));
         p_ab = clamp32(p01 - round_shr(k0 * p01, 24));
         p_ba = clamp32(p10 - round_shr(k1 * p00, 24));
         p_bb = clamp32(p11 - round_shr(k1 * p01, 24));
      end
   endtask

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         noise_meas = longint'(kabf_pkg::MEASURE_NOISE_RST);
         noise_angle = longint'(kabf_pkg::ANGLE_NOISE_RST);
         noise_bias = longint'(kabf_pkg::BIAS_NOISE_RST);
         est_angle = 0;
         est_bias = 0;
         p_aa = 0;
         p_ab = 0;
         p_ba = 0;
         p_bb = 0;
         estimates_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               kabf_pkg::CSR_MEASURE_NOISE: noise_meas = longint'(csr_write_data);
               kabf_pkg::CSR_ANGLE_NOISE:   noise_angle = longint'(csr_write_data);
               kabf_pkg::CSR_BIAS_NOISE:    noise_bias = longint'(csr_write_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            filter_step(req_kind, req_measured_angle, req_gyro_rate, req_time_step);
            want.angle = est_angle[31:0];
            want.bias = est_bias[31:0];
            estimates_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (estimates_due.size() == 0) begin
               $error("unexpected response: angle_estimate %0d, bias_estimate %0d",
                      rsp_angle_estimate, rsp_bias_estimate);
               fail_count <= fail_count + 1;
            end else begin
               want = estimates_due.pop_front();
               if (rsp_angle_estimate !== want.angle || rsp_bias_estimate !== want.bias)
                  fail_count <= fail_count + 1;
               if (rsp_angle_estimate !== want.angle)
                  $error("angle_estimate: expected %0d, got %0d",
                         want.angle, rsp_angle_estimate);
               if (rsp_bias_estimate !== want.bias)
                  $error("bias_estimate: expected %0d, got %0d",
                         want.bias, rsp_bias_estimate);
            end
         end
      end
      outstanding <= estimates_due.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the angle and bias filter through directed and random requests under
// several noise settings and idling patterns; a checker beside the block
// predicts and compares every response
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int PHASE_ITEMS = 240;
   localparam int NUM_PHASES  = 6;
   localparam logic [kabf_pkg::CSR_IDX_WIDTH-1:0] CSR_NONE = 2'd3;

   typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_kind;
   logic signed [31:0]                    req_measured_angle;
   logic signed [31:0]                    req_gyro_rate;
   logic [15:0]                           req_time_step;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [31:0]                    rsp_angle_estimate;
   logic signed [31:0]                    rsp_bias_estimate;
   logic                                  csr_write_enable;
   logic [kabf_pkg::CSR_IDX_WIDTH-1:0]    csr_index;
   logic [kabf_pkg::CSR_WIDTH-1:0]        csr_write_data;
   int                                    fail_count;
   int                                    outstanding;
   int                                    cycles = 0;
   idle_mode_type                         idle_mode;

   kalman_angle_bias_filter dut (.*);

   kabf_checker watcher (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (idle_mode == IDLE_RECV)
         rsp_ready <= ($urandom_range(99) >= 76);
      else if (idle_mode == IDLE_BOTH)
         rsp_ready <= ($urandom_range(99) >= 14);
      else
         rsp_ready <= 1'b1;
   end

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SEND) return $urandom_range(99) < 76;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 14;
      return 1'b0;
   endfunction

   task automatic send_request(input logic kind, input logic signed [31:0] meas,
                               input logic signed [31:0] rate, input logic [15:0] dt);
      @(negedge clock);
      if (sender_idles()) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (sender_idles());
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_measured_angle <= meas;
      req_gyro_rate <= rate;
      req_time_step <= dt;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic write_csr(input logic [kabf_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [kabf_pkg::CSR_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0 || rsp_valid) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_noise(input logic [kabf_pkg::CSR_WIDTH-1:0] r,
                              input logic [kabf_pkg::CSR_WIDTH-1:0] qa,
                              input logic [kabf_pkg::CSR_WIDTH-1:0] qb);
      write_csr(kabf_pkg::CSR_MEASURE_NOISE, r);
      write_csr(kabf_pkg::CSR_ANGLE_NOISE, qa);
      write_csr(kabf_pkg::CSR_BIAS_NOISE, qb);
   endtask

   function automatic logic signed [31:0] moderate_value();
      return $signed($urandom) >>> $urandom_range(8, 14);
   endfunction

   task automatic random_request();
      logic kind;
      kind = ($urandom_range(99) >= 8);
      if ($urandom_range(99) < 80)
         send_request(kind, moderate_value(), moderate_value(),
                      16'($urandom_range(0, 3000)));
      else
         send_request(kind, $urandom, $urandom, 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      reset = 1'b1;
      idle_mode = IDLE_NONE;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_measured_angle = '0;
      req_gyro_rate = '0;
      req_time_step = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset noise values, extremes of the fields
      send_request(1'b1, 32'sd65536, 32'sd6553, 16'd1000);
      send_request(1'b0, 32'h7fffffff, '0, '0);
      send_request(1'b1, 32'h7fffffff, 32'h7fffffff, 16'hffff);
      send_request(1'b1, 32'h80000000, 32'h80000000, 16'hffff);
      send_request(1'b0, 32'h80000000, 32'h7fffffff, 16'hffff);
      send_request(1'b1, 32'h7fffffff, 32'h80000000, 16'hffff);
      send_request(1'b1, 32'h7fffffff, 32'h7fffffff, 16'd0);
      send_request(1'b0, '0, '0, '0);
      send_request(1'b1, 32'sd1000, -32'sd5000, 16'd655);
      send_request(1'b1, -32'sd1000, 32'sd5000, 16'd65535);
      drain();

      // zero noise: innovation variance stays nonpositive, gains are zero
      write_noise('0, '0, '0);
      write_csr(CSR_NONE, 31'h7fffffff);
      send_request(1'b0, 32'sd12345, '0, '0);
      send_request(1'b1, 32'sd99999, 32'sd100, 16'd0);
      send_request(1'b1, -32'sd99999, 32'sd100, 16'd65535);
      send_request(1'b1, 32'sd5, -32'sd7, 16'd1);
      drain();

      // largest noise values
      write_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      send_request(1'b0, '0, '0, '0);
      send_request(1'b1, 32'h7fffffff, 32'h7fffffff, 16'hffff);
      send_request(1'b1, 32'h80000000, 32'h80000000, 16'hffff);
      send_request(1'b1, 32'sd3, 32'h80000000, 16'hffff);
      send_request(1'b1, 32'h80000000, 32'sd3, 16'h8000);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0, 5: write_noise(kabf_pkg::MEASURE_NOISE_RST, kabf_pkg::ANGLE_NOISE_RST,
                              kabf_pkg::BIAS_NOISE_RST);
            1: write_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
            2: write_noise('0, '0, '0);
            3: write_noise(31'($urandom), 31'($urandom), 31'($urandom));
            default: write_noise(31'($urandom_range(0, 1 << 25)),
                                 31'($urandom_range(0, 1 << 22)),
                                 31'($urandom_range(0, 1 << 22)));
         endcase
         idle_mode = idle_mode_type'(ph % 4);
         send_request(1'b0, moderate_value(), '0, '0);
         for (int i = 1; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) idle_mode = idle_mode_type'((ph + 1) % 4);
            random_request();
         end
         drain();
      end

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
rtl/kabf_pkg.sv
rtl/kalman_angle_bias_filter.sv
test/kabf_checker.sv
test/tb.sv
